@@ src/dmbc_pkg.sv @@
// Package for the disc move block: request, response and wall types, and a 24-bit saturation function.
// No dependencies.
package dmbc_pkg;

   typedef struct packed {
      logic        operation;
      logic [3:0]  wall_index;
      logic signed [23:0] wall_left;
      logic signed [23:0] wall_bottom;
      logic [22:0] wall_width;
      logic [22:0] wall_height;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [22:0] radius;
      logic signed [23:0] speed;
      logic [15:0] heading;
      logic [15:0] time_step;
   } req_type;

   typedef struct packed {
      logic signed [23:0] new_x;
      logic signed [23:0] new_y;
      logic        x_blocked;
      logic        y_blocked;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] left;
      logic signed [23:0] bottom;
      logic [22:0] width;
      logic [22:0] height;
   } wall_type;

   localparam int OpWrite = 0;

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607) begin
         return 24'sh7fffff;
      end else if (v < -26'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

endpackage

@@ src/dmbc_touch.sv @@
// One wall test: does a disc overlap a box, by the clamped-point distance.
// Depends on dmbc_pkg.
module dmbc_touch import dmbc_pkg::*; (
   input  wall_type           wall,
   input  logic signed [23:0] cx,
   input  logic signed [23:0] cy,
   input  logic [22:0]        rad,
   output logic               hit
);
   logic signed [25:0] rx, ty, px, py, ex, ey;
   logic [51:0] d2;
   logic [45:0] r2;

   always_comb begin
      rx = 26'(wall.left) + 26'($signed({1'b0, wall.width}));
      ty = 26'(wall.bottom) + 26'($signed({1'b0, wall.height}));
      px = 26'(cx);
      if (px < 26'(wall.left)) begin
         px = 26'(wall.left);
      end
      if (px > rx) begin
         px = rx;
      end
      py = 26'(cy);
      if (py < 26'(wall.bottom)) begin
         py = 26'(wall.bottom);
      end
      if (py > ty) begin
         py = ty;
      end
      ex = 26'(cx) - px;
      ey = 26'(cy) - py;
      d2 = $unsigned(52'(ex) * 52'(ex) + 52'(ey) * 52'(ey));
      r2 = rad * rad;
      hit = d2 < 52'(r2);
   end
endmodule

@@ src/disc_move_with_box_collision.sv @@
// Top level of the disc move block: wall table, sine table, pipeline.
// Depends on dmbc_pkg and dmbc_touch.
//  channel | direction | handshake
//  req     | in        | req_valid / req_ready
//  rsp     | out       | rsp_valid / rsp_ready
//  csr     | in        | csr_write, no wait
// Six register stages: sine lookup, two multiply stages, x add, x walls, y walls.
// One request enters per cycle unless a stall or a waiting wall write holds it.
// A wall write waits until no earlier move still has a wall test to do.
// A stall holds every stage in place. Reset empties the pipe and clears the walls.
module disc_move_with_box_collision import dmbc_pkg::*; #(
   parameter int MAX_WALLS = 16,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write,
   input  logic [4:0] csr_data
);
   localparam int DW = $clog2(SINE_TABLE_DEPTH) + 1;
   localparam logic [63:0] HalfPi = 64'd1686629713;

   function automatic logic [15:0] qsine(input int unsigned i);
      logic [63:0] x, x2, term, sum, r;
      x = (HalfPi * 64'(i)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32768) r = 64'd32768;
      return r[15:0];
   endfunction

   logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
   always_comb begin
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) sine_rom[i] = qsine(i);
   end

   function automatic logic signed [16:0] trig(input logic [15:0] h);
      logic [DW-1:0] idx;
      logic [15:0] v;
      idx = DW'((32'(h[13:0]) * SINE_TABLE_DEPTH) >> 14);
      if (h[14]) idx = DW'(SINE_TABLE_DEPTH) - idx;
      v = sine_rom[idx];
      return h[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

   function automatic logic signed [25:0] round31(input logic signed [56:0] p);
      logic [56:0] m;
      m = p[56] ? 57'(-p) : 57'(p);
      m = (m + 57'(64'd1 << 30)) >> 31;
      return p[56] ? -$signed(m[25:0]) : $signed(m[25:0]);
   endfunction

   logic [4:0] count_ff;
   wall_type walls_ff [MAX_WALLS];
   logic [5:0] v_ff;
   logic adv;
   logic wr_hold;
   assign adv = !rsp_valid || rsp_ready;
   assign wr_hold = (req_data.operation == 1'(OpWrite)) && (|v_ff[4:0]);
   assign req_ready = adv && !wr_hold;
   assign rsp_valid = v_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write) begin
         count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WALLS; i++) walls_ff[i] <= '0;
      end else if (req_valid && req_ready && req_data.operation == 1'(OpWrite)
                   && 32'(req_data.wall_index) < MAX_WALLS) begin
         walls_ff[req_data.wall_index] <= {req_data.wall_left, req_data.wall_bottom,
                                           req_data.wall_width, req_data.wall_height};
      end
   end

   logic [MAX_WALLS-1:0] act;
   always_comb begin
      for (int i = 0; i < MAX_WALLS; i++) act[i] = 32'(i) < 32'(count_ff);
   end

   // stage registers
   logic signed [23:0] x0_ff [6], y0_ff [6];
   logic [22:0] r_ff [6];
   logic signed [16:0] c_ff, s_ff, cr_ff;
   logic signed [23:0] sp_ff;
   logic [15:0] dt_ff;
   logic signed [40:0] cp_ff, spr_ff;
   logic signed [25:0] dx_ff, dy_ff, dy2_ff, dy3_ff;
   logic signed [23:0] xn_ff, xr_ff, xr2_ff, yo_ff;
   logic xb_ff, xb2_ff, yb_ff;

   logic [MAX_WALLS-1:0] hx, hy;
   logic signed [23:0] yn;
   assign yn = sat24(26'(y0_ff[4]) + dy3_ff);
   for (genvar g = 0; g < MAX_WALLS; g++) begin : g_w
      dmbc_touch ux (.wall(walls_ff[g]), .cx(xn_ff), .cy(y0_ff[3]), .rad(r_ff[3]),
                     .hit(hx[g]));
      dmbc_touch uy (.wall(walls_ff[g]), .cx(xr_ff), .cy(yn), .rad(r_ff[4]),
                     .hit(hy[g]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], req_valid && req_data.operation != 1'(OpWrite)};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 1; i < 6; i++) begin
            x0_ff[i] <= x0_ff[i-1];
            y0_ff[i] <= y0_ff[i-1];
            r_ff[i] <= r_ff[i-1];
         end
         x0_ff[0] <= req_data.pos_x;
         y0_ff[0] <= req_data.pos_y;
         r_ff[0] <= req_data.radius;
         c_ff <= trig(16'(req_data.heading + 16'd16384));
         s_ff <= trig(req_data.heading);
         sp_ff <= req_data.speed;
         dt_ff <= req_data.time_step;
         cp_ff <= 41'(sp_ff) * 41'($signed({1'b0, dt_ff}));
         spr_ff <= 41'(s_ff);
         cr_ff <= c_ff;
         dx_ff <= round31(57'(cp_ff) * 57'(cr_ff));
         dy_ff <= round31(57'(cp_ff) * 57'(spr_ff));
         xn_ff <= sat24(26'(x0_ff[2]) + dx_ff);
         dy2_ff <= dy_ff;
         dy3_ff <= dy2_ff;
         xb_ff <= |(hx & act);
         xr_ff <= (|(hx & act)) ? x0_ff[3] : xn_ff;
         xb2_ff <= xb_ff;
         xr2_ff <= xr_ff;
         yb_ff <= |(hy & act);
         yo_ff <= (|(hy & act)) ? y0_ff[4] : yn;
      end
   end

   always_comb begin
      rsp_data.new_x = xr2_ff;
      rsp_data.new_y = yo_ff;
      rsp_data.x_blocked = xb2_ff;
      rsp_data.y_blocked = yb_ff;
   end
endmodule

@@ tb/disc_move_with_box_collision_test.sv @@
// Self-checking testbench for the disc move block with wall collision.
// Depends on dmbc_pkg and disc_move_with_box_collision.
`timescale 1ns / 100ps

module disc_move_with_box_collision_test;
   import dmbc_pkg::*;

   localparam int WALL_SLOTS = 16;
   localparam int SINE_DEPTH = 256;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [4:0] csr_data = '0;

   disc_move_with_box_collision uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   req_type pending_requests[$];
   rsp_type expected_moves[$];
   wall_type wall_model[WALL_SLOTS];
   logic [4:0] wall_limit;
   longint sine_points[SINE_DEPTH + 1];
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   bit all_sent = 0;
   bit req_taken = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint quarter_sine(longint i);
      longint unsigned x, x2, term, sum, r;
      x = (64'd1686629713 * i) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + (64'd1 << 14)) >> 15;
      if (r > 32768) begin
         r = 32768;
      end
      return r;
   endfunction

   function automatic longint sine_at(logic [15:0] h);
      int q;
      int idx;
      q = h[15:14];
      idx = (int'(h[13:0]) * SINE_DEPTH) >> 14;
      if (q % 2 == 1) begin
         idx = SINE_DEPTH - idx;
      end
      return (q >= 2) ? -sine_points[idx] : sine_points[idx];
   endfunction

   function automatic longint step_distance(longint dt, longint spd, longint trig);
      longint prod, mag;
      prod = dt * spd * trig;
      mag = (prod < 0) ? -prod : prod;
      mag = (mag + (64'sd1 << 30)) >>> 31;
      return (prod < 0) ? -mag : mag;
   endfunction

   function automatic longint clamp_position(longint v);
      if (v > 8388607) begin
         return 8388607;
      end else if (v < -8388608) begin
         return -8388608;
      end
      return v;
   endfunction

   function automatic bit hits_wall(longint cx, longint cy, longint rad);
      int n;
      longint px, py, lo, bo, hi_x, hi_y, ex, ey;
      n = (wall_limit > WALL_SLOTS) ? WALL_SLOTS : wall_limit;
      for (int i = 0; i < n; i++) begin
         lo = longint'(wall_model[i].left);
         bo = longint'(wall_model[i].bottom);
         hi_x = lo + longint'(wall_model[i].width);
         hi_y = bo + longint'(wall_model[i].height);
         px = cx;
         py = cy;
         if (px < lo) px = lo;
         if (px > hi_x) px = hi_x;
         if (py < bo) py = bo;
         if (py > hi_y) py = hi_y;
         ex = cx - px;
         ey = cy - py;
         if (ex * ex + ey * ey < rad * rad) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_move(req_type r);
      longint x0, y0, rad, dx, dy, x, y;
      rsp_type res;
      if (r.operation == 1'(OpWrite)) begin
         wall_model[r.wall_index] = '{r.wall_left, r.wall_bottom, r.wall_width,
                                      r.wall_height};
         return;
      end
      x0 = longint'(r.pos_x);
      y0 = longint'(r.pos_y);
      rad = longint'(r.radius);
      dx = step_distance(longint'(r.time_step), longint'(r.speed),
                         sine_at(r.heading + 16'd16384));
      dy = step_distance(longint'(r.time_step), longint'(r.speed), sine_at(r.heading));
      res = '0;
      x = clamp_position(x0 + dx);
      if (hits_wall(x, y0, rad)) begin
         x = x0;
         res.x_blocked = 1'b1;
      end
      y = clamp_position(y0 + dy);
      if (hits_wall(x, y, rad)) begin
         y = y0;
         res.y_blocked = 1'b1;
      end
      res.new_x = x[23:0];
      res.new_y = y[23:0];
      expected_moves.push_back(res);
   endfunction

   function automatic req_type random_request(bit is_move);
      req_type r;
      r = '0;
      r.operation = is_move;
      r.wall_index = $urandom_range(0, 15);
      r.wall_left = $urandom_range(0, 1) ? 24'($urandom)
                    : 24'($signed($urandom_range(0, 16000)) - 8000);
      r.wall_bottom = $urandom_range(0, 1) ? 24'($urandom)
                      : 24'($signed($urandom_range(0, 16000)) - 8000);
      r.wall_width = $urandom_range(0, 3) == 0 ? 23'($urandom) : 23'($urandom_range(0, 6000));
      r.wall_height = $urandom_range(0, 3) == 0 ? 23'($urandom) : 23'($urandom_range(0, 6000));
      r.pos_x = $urandom_range(0, 4) == 0 ? 24'($urandom)
                : 24'($signed($urandom_range(0, 16000)) - 8000);
      r.pos_y = $urandom_range(0, 4) == 0 ? 24'($urandom)
                : 24'($signed($urandom_range(0, 16000)) - 8000);
      r.radius = $urandom_range(0, 4) == 0 ? 23'($urandom) : 23'($urandom_range(0, 3000));
      r.speed = $urandom_range(0, 3) == 0 ? 24'($urandom)
                : 24'($signed($urandom_range(0, 8000)) - 4000);
      r.heading = 16'($urandom);
      r.time_step = 16'($urandom);
      return r;
   endfunction

   task automatic run_phase(logic [4:0] count, int n);
      req_type r;
      csr_data <= count;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      wall_limit = count;
      for (int i = 0; i < n; i++) begin
         r = random_request($urandom_range(0, 3) != 0);
         pending_requests.push_back(r);
      end
      wait (pending_requests.size() == 0 && expected_moves.size() == 0);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      req_type r;
      for (int i = 0; i <= SINE_DEPTH; i++) sine_points[i] = quarter_sine(i);
      for (int i = 0; i < WALL_SLOTS; i++) wall_model[i] = '0;
      wall_limit = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: empty table first, then a known box, extremes of every field.
      r = '0;
      r.operation = 1'b1;
      pending_requests.push_back(r);
      r.pos_x = 24'sh7fffff; r.pos_y = 24'sh800000; r.speed = 24'sh7fffff;
      r.time_step = 16'hffff; r.radius = 23'h7fffff; r.heading = 16'h0000;
      pending_requests.push_back(r);
      r.heading = 16'h4000; pending_requests.push_back(r);
      r.heading = 16'h8000; r.speed = 24'sh800000; pending_requests.push_back(r);
      r.heading = 16'hffff; pending_requests.push_back(r);
      wait (pending_requests.size() == 0 && expected_moves.size() == 0);
      repeat (12) @(negedge clock);
      csr_data <= 5'd31;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      wall_limit = 5'd31;
      r = '0;
      r.wall_left = 24'sd1000; r.wall_bottom = -24'sd500;
      r.wall_width = 23'd2000; r.wall_height = 23'd1000;
      pending_requests.push_back(r);
      r.wall_index = 4'd15; r.wall_left = 24'sh800000; r.wall_bottom = 24'sh7fffff;
      r.wall_width = 23'h7fffff; r.wall_height = 23'h7fffff;
      pending_requests.push_back(r);
      r = '0;
      r.operation = 1'b1;
      r.pos_x = 24'sd800; r.radius = 23'd256; r.speed = 24'sd2000;
      r.time_step = 16'h8000;
      pending_requests.push_back(r);
      r.radius = 23'd0; pending_requests.push_back(r);
      r.pos_x = 24'sd1500; r.radius = 23'd100; pending_requests.push_back(r);
      r.pos_x = 24'sd500; r.heading = 16'h4000; r.radius = 23'd200;
      pending_requests.push_back(r);
      r.pos_x = 24'sd1200; r.pos_y = 24'sd700; r.heading = 16'hc000; r.radius = 23'd150;
      pending_requests.push_back(r);
      r.pos_x = 24'sh7fffff; r.pos_y = 24'sh7fffff; r.heading = 16'h2000;
      r.speed = 24'sh7fffff; r.time_step = 16'hffff; r.radius = 23'd10;
      pending_requests.push_back(r);
      wait (pending_requests.size() == 0 && expected_moves.size() == 0);
      repeat (12) @(negedge clock);
      run_phase(5'd16, 350);
      run_phase(5'd0, 150);
      run_phase(5'd3, 250);
      run_phase(5'd20, 300);
      all_sent = 1;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            void'(pending_requests.pop_front());
         end
         if (!req_valid || req_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               burst_left--;
               req_valid <= 1'b1;
               req_data <= pending_requests[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         rsp_ready <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_move(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response %h", rsp_data);
            end else if (rsp_data !== expected_moves[0]) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: expected x %0d y %0d xb %b yb %b, got x %0d y %0d xb %b yb %b",
                     expected_moves[0].new_x, expected_moves[0].new_y,
                     expected_moves[0].x_blocked, expected_moves[0].y_blocked,
                     rsp_data.new_x, rsp_data.new_y, rsp_data.x_blocked, rsp_data.y_blocked);
               end
               void'(expected_moves.pop_front());
            end else begin
               void'(expected_moves.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else if (all_sent && expected_moves.size() == 0 && pending_requests.size() == 0
                      && idle_cycles >= 20) begin
            if (mismatches == 0) begin
               $display("SUCCESS");
            end else begin
               $display("FAILURE");
            end
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
src/dmbc_pkg.sv
src/dmbc_touch.sv
src/disc_move_with_box_collision.sv
tb/disc_move_with_box_collision_test.sv
